@@ src/actr_pkg.sv @@
// Shared types, constants and AES helper functions for the CTR core.
package actr_pkg;

  localparam int unsigned NumRounds   = 14;
  localparam int unsigned NumRkWords  = 30;   // 64-bit round key words
  localparam int unsigned NumKeyRegs  = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CountW      = 5;
  localparam logic [CountW-1:0] MaxBytes = 5'd16;

  localparam logic [CfgIdxW-1:0] RegKey0 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEXP,
    ST_RUN,
    ST_OUT
  } actr_state_t;

  typedef struct packed {
    logic       load;     // load state from counter, apply round key 0
    logic       round;    // apply one full/last round
    logic       last;     // final round: no MixColumns
  } actr_rnd_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits in bits 8i+7:8i.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[(c*4+r)*8 +: 8] = SBOX[s[(((c + r) % 4)*4 + r)*8 +: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      a0 = s[(c*4)*8 +: 8];
      a1 = s[(c*4+1)*8 +: 8];
      a2 = s[(c*4+2)*8 +: 8];
      a3 = s[(c*4+3)*8 +: 8];
      x  = a0 ^ a1 ^ a2 ^ a3;
      t[(c*4)*8 +: 8]   = a0 ^ x ^ gf_dbl(a0 ^ a1);
      t[(c*4+1)*8 +: 8] = a1 ^ x ^ gf_dbl(a1 ^ a2);
      t[(c*4+2)*8 +: 8] = a2 ^ x ^ gf_dbl(a2 ^ a3);
      t[(c*4+3)*8 +: 8] = a3 ^ x ^ gf_dbl(a3 ^ a0);
    end
    mix_cols = t;
  endfunction

endpackage

@@ src/actr_stream_if.sv @@
// Valid/ready stream interface carrying one payload struct.
interface actr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ src/aes256_ctr_le_counter_core.sv @@
// Top level of the AES-256 CTR core with little-endian counter.
//
// Input channel in_: a chunk of up to 16 bytes, its byte count and a start
// flag. A start chunk latches the key registers, expands the key and clears
// the counter before use. Each chunk bumps the 128-bit counter, encrypts it
// with 14 rounds on one shared round unit (one round a cycle, round keys
// read from a registered memory) and XORs the valid bytes. A new chunk is
// taken only once the last chunk's result has been handed off, since the
// single round unit and the key memory serve one chunk at a time.
// Result channel out_: data with unused bytes zeroed, plus valid_bytes. The
// result sits in an output register; while the receiver stalls, the core
// holds it and takes no new chunk.
// Configuration: cfg_we, cfg_idx, cfg_data write key words 0..3, which the
// user writes only while idle; the core does not enforce it. Reset clears the
// control state and counter; round keys stay undefined until a start chunk.
module aes256_ctr_le_counter_core import actr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [63:0]  in_chunk_low,
  input  logic [63:0]  in_chunk_high,
  input  logic [4:0]   in_byte_count,
  input  logic         in_start_req,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  out_result_low,
  output logic [63:0]  out_result_high,
  output logic [4:0]   out_valid_bytes,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [63:0]  cfg_data
);

  actr_state_t   st_r, st_nxt;
  logic [63:0]   key_r [NumKeyRegs];
  logic [127:0]  ctr_r, ctr_nxt;
  logic [127:0]  data_r;
  logic [4:0]    cnt_r;
  logic [3:0]    rnd_r, rnd_nxt;
  logic [127:0]  res_r;
  logic [4:0]    vb_r;
  logic          kx_start, kx_busy, accept, finish;
  logic [127:0]  rkey, aes_st, ks, mask;
  actr_rnd_ctl_t ctl;
  logic          fin_d_r;
  logic          ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumKeyRegs; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegKey0: key_r[0] <= cfg_data;
        RegKey1: key_r[1] <= cfg_data;
        RegKey2: key_r[2] <= cfg_data;
        RegKey3: key_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && in_ready;
  assign kx_start = accept && in_start_req;
  assign in_ready = (st_r == ST_IDLE);

  actr_keyexp u_kx (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kx_start),
    .key      ({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .busy     (kx_busy),
    .rd_round (rnd_r),
    .rd_key   (rkey)
  );

  actr_round u_rnd (
    .clk   (clk),
    .ctl   (ctl),
    .ctr   (ctr_r),
    .rkey  (rkey),
    .state (aes_st)
  );

  // Sequencer: rnd_r is the key memory address; the data arrives in the cycle after.
  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    ctr_nxt = ctr_r;
    ctl     = '0;
    finish  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          ctr_nxt = (in_start_req ? 128'd0 : ctr_r) + 128'd1;
          rnd_nxt = 4'd0;
          st_nxt  = in_start_req ? ST_KEXP : ST_RUN;
        end
      end
      ST_KEXP: begin
        if (!kx_busy) st_nxt = ST_RUN;
      end
      ST_RUN: begin
        // key for round rnd_r-1 is on rkey now
        ctl.load  = (rnd_r == 4'd1);
        ctl.round = (rnd_r > 4'd1);
        ctl.last  = (rnd_r == 4'(NumRounds + 1));
        if (rnd_r == 4'(NumRounds + 1)) begin
          finish = 1'b1;
          st_nxt = ST_OUT;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      ST_OUT: begin
        // hold until the result transaction completes
        if (ov_r && out_ready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ctr_r <= '0;
      rnd_r <= '0;
    end else begin
      st_r  <= st_nxt;
      ctr_r <= ctr_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= {in_chunk_high, in_chunk_low};
      cnt_r  <= (in_byte_count > MaxBytes) ? MaxBytes : in_byte_count;
    end
  end

  // last round lands in the round unit at finish; combine in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) fin_d_r <= 1'b0;
    else        fin_d_r <= finish;
  end

  always_comb begin
    ks = aes_st;
    for (int i = 0; i < 16; i++) begin
      mask[i*8 +: 8] = (5'(i) < cnt_r) ? 8'hff : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_d_r) begin
      res_r <= (data_r ^ ks) & mask;
      vb_r  <= cnt_r;
    end
  end

  // ST_OUT is entered after finish; the result register fills when fin_d_r is set
  always_ff @(posedge clk) begin
    if (!rst_n)                 ov_r <= 1'b0;
    else if (fin_d_r)           ov_r <= 1'b1;
    else if (ov_r && out_ready) ov_r <= 1'b0;
  end

  assign out_valid       = ov_r;
  assign out_result_low  = res_r[63:0];
  assign out_result_high = res_r[127:64];
  assign out_valid_bytes = vb_r;

endmodule

@@ src/actr_keyexp.sv @@
// Iterative AES-256 key expansion: one 32-bit word per cycle into the round key memory.
module actr_keyexp import actr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] key,
  output logic         busy,
  input  logic [3:0]   rd_round,
  output logic [127:0] rd_key
);

  // 60 words of 32 bits; the last eight words produced form the sliding window.
  logic [255:0] win_r, win_nxt;
  logic [5:0]   g_r, g_nxt;       // index of word being produced
  logic [7:0]   rc_r, rc_nxt;
  logic         busy_r, busy_nxt;
  logic [127:0] mem [NumRounds+1];
  logic [127:0] rd_key_r;
  logic [31:0]  t, w_new;
  logic         wr_en;
  logic [3:0]   wr_addr;

  always_comb begin
    t = win_r[255:224];
    if (g_r[2:0] == 3'd0) begin
      t = {SBOX[t[7:0]], SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]] ^ rc_r};
    end else if (g_r[2:0] == 3'd4) begin
      t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    end
    w_new    = win_r[31:0] ^ t;
    win_nxt  = win_r;
    g_nxt    = g_r;
    rc_nxt   = rc_r;
    busy_nxt = busy_r;
    wr_en    = 1'b0;
    wr_addr  = g_r[5:2];
    if (start) begin
      win_nxt  = key;
      g_nxt    = 6'd8;
      rc_nxt   = 8'h01;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      win_nxt = {w_new, win_r[255:32]};
      g_nxt   = g_r + 6'd1;
      if (g_r[2:0] == 3'd0) rc_nxt = gf_dbl(rc_r);
      // a 128-bit round key completes every fourth word
      wr_en = (g_r[1:0] == 2'd3);
      if (g_r == 6'd59) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    win_r <= win_nxt;
    g_r   <= g_nxt;
    rc_r  <= rc_nxt;
  end

  // key 0 and 1 come straight from the key; store them at start
  always_ff @(posedge clk) begin
    if (start) begin
      mem[0] <= key[127:0];
      mem[1] <= key[255:128];
    end else if (wr_en) begin
      mem[wr_addr] <= {w_new, win_r[255:160]};
    end
    rd_key_r <= mem[rd_round];
  end

  assign rd_key = rd_key_r;
  assign busy   = busy_r;

endmodule

@@ src/actr_round.sv @@
// Shared AES round unit: holds the state and applies one round per cycle.
module actr_round import actr_pkg::*; (
  input  logic          clk,
  input  actr_rnd_ctl_t ctl,
  input  logic [127:0]  ctr,
  input  logic [127:0]  rkey,
  output logic [127:0]  state
);

  logic [127:0] st_r, st_nxt, ss;

  always_comb begin
    ss     = sub_shift(st_r);
    st_nxt = st_r;
    if (ctl.load) begin
      st_nxt = ctr ^ rkey;
    end else if (ctl.round) begin
      st_nxt = (ctl.last ? ss : mix_cols(ss)) ^ rkey;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign state = st_r;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the AES-256 CTR core with little-endian counter.
module tb_top import actr_pkg::*; ();

  typedef struct packed {
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
    logic [4:0]  byte_count;
    logic        start_req;
  } chunk_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [4:0]  valid_bytes;
  } keystream_out_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [63:0] cfg_data;

  actr_stream_if #(.payload_t(chunk_t))         in_ch ();
  actr_stream_if #(.payload_t(keystream_out_t)) out_ch ();

  aes256_ctr_le_counter_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_chunk_low   (in_ch.payload.chunk_low),
    .in_chunk_high  (in_ch.payload.chunk_high),
    .in_byte_count  (in_ch.payload.byte_count),
    .in_start_req   (in_ch.payload.start_req),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_result_low (out_ch.payload.result_low),
    .out_result_high(out_ch.payload.result_high),
    .out_valid_bytes(out_ch.payload.valid_bytes),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data)
  );

  // Predictor state
  logic [63:0]  key_shadow [NumKeyRegs];
  logic [127:0] rk_table [NumRounds+1];
  logic [127:0] ctr_value;
  keystream_out_t pending_results [$];

  int  error_count = 0;
  bit  quiet = 0;
  int  cycle_count = 0;

  always #1 clk = ~clk;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void build_rk_table();
    logic [7:0] w [240];
    logic [7:0] t [4];
    logic [7:0] rcon;
    logic [7:0] first;
    rcon = 8'h01;
    for (int i = 0; i < 32; i++) w[i] = key_shadow[i/8][(i%8)*8 +: 8];
    for (int g = 32; g < 240; g += 4) begin
      for (int i = 0; i < 4; i++) t[i] = w[g-4+i];
      if (g % 32 == 0) begin
        first = t[0];
        t[0] = SBOX[t[1]] ^ rcon;
        t[1] = SBOX[t[2]];
        t[2] = SBOX[t[3]];
        t[3] = SBOX[first];
        rcon = xtime(rcon);
      end else if (g % 32 == 16) begin
        for (int i = 0; i < 4; i++) t[i] = SBOX[t[i]];
      end
      for (int i = 0; i < 4; i++) w[g+i] = w[g-32+i] ^ t[i];
    end
    for (int r = 0; r <= NumRounds; r++)
      for (int i = 0; i < 16; i++) rk_table[r][i*8 +: 8] = w[r*16+i];
  endfunction

  function automatic logic [127:0] cipher_blk(input logic [127:0] blk);
    logic [127:0] s;
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, x;
    s = blk ^ rk_table[0];
    for (int r = 1; r <= NumRounds; r++) begin
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++)
          t[(c*4+k)*8 +: 8] = SBOX[s[(((c+k)%4)*4+k)*8 +: 8]];
      s = t;
      if (r != NumRounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[(c*4)*8 +: 8];
          a1 = t[(c*4+1)*8 +: 8];
          a2 = t[(c*4+2)*8 +: 8];
          a3 = t[(c*4+3)*8 +: 8];
          x  = a0 ^ a1 ^ a2 ^ a3;
          s[(c*4)*8 +: 8]   = a0 ^ x ^ xtime(a0 ^ a1);
          s[(c*4+1)*8 +: 8] = a1 ^ x ^ xtime(a1 ^ a2);
          s[(c*4+2)*8 +: 8] = a2 ^ x ^ xtime(a2 ^ a3);
          s[(c*4+3)*8 +: 8] = a3 ^ x ^ xtime(a3 ^ a0);
        end
      end
      s = s ^ rk_table[r];
    end
    return s;
  endfunction

  function automatic keystream_out_t predict_chunk(input chunk_t c);
    keystream_out_t r;
    logic [127:0] ks;
    logic [127:0] data;
    int n;
    n = (c.byte_count > MaxBytes) ? MaxBytes : c.byte_count;
    if (c.start_req) begin
      build_rk_table();
      ctr_value = '0;
    end
    ctr_value = ctr_value + 128'd1;
    ks = cipher_blk(ctr_value);
    data = {c.chunk_high, c.chunk_low} ^ ks;
    for (int i = n; i < 16; i++) data[i*8 +: 8] = 8'h00;
    r.result_low  = data[63:0];
    r.result_high = data[127:64];
    r.valid_bytes = n[4:0];
    return r;
  endfunction

  // Sender: optional gap, then hold valid until the transaction is accepted.
  task automatic send_chunk(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] cnt, input logic start);
    chunk_t c;
    c = '{chunk_low: lo, chunk_high: hi, byte_count: cnt, start_req: start};
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_chunk(c));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key(input logic [CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_shadow[idx] = data;
  endtask

  task automatic load_key(input logic [255:0] k);
    write_key(RegKey0, k[63:0]);
    write_key(RegKey1, k[127:64]);
    write_key(RegKey2, k[191:128]);
    write_key(RegKey3, k[255:192]);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [255:0] rand_key();
    return {rand64(), rand64(), rand64(), rand64()};
  endfunction

  // Extreme keys and data, byte counts including zero, partial and oversize ones.
  task automatic test_directed();
    load_key('0);
    send_chunk('0, '0, 5'd16, 1'b1);
    send_chunk('1, '1, 5'd16, 1'b0);
    send_chunk(rand64(), rand64(), 5'd0, 1'b0);
    send_chunk(rand64(), rand64(), 5'd1, 1'b0);
    send_chunk(rand64(), rand64(), 5'd8, 1'b0);
    send_chunk(rand64(), rand64(), 5'd9, 1'b0);
    send_chunk(rand64(), rand64(), 5'd15, 1'b0);
    send_chunk('1, '1, 5'd17, 1'b0);
    send_chunk('1, '1, 5'd31, 1'b0);
    drain();
    load_key('1);
    send_chunk('1, '0, 5'd16, 1'b1);
    send_chunk('0, '1, 5'd7, 1'b0);
    // restart with the same key: counter must go back to one
    send_chunk('0, '0, 5'd16, 1'b1);
    send_chunk(rand64(), rand64(), 5'd24, 1'b0);
    drain();
    // key registers only take effect at the next start
    write_key(RegKey2, 64'h0123456789abcdef);
    send_chunk('0, '0, 5'd16, 1'b0);
    send_chunk('0, '0, 5'd16, 1'b1);
    send_chunk('0, '0, 5'd3, 1'b1);
    drain();
  endtask

  // Messages of random length under a series of random keys.
  task automatic test_random_streams(input int num_chunks);
    int left;
    int len;
    logic [4:0] cnt;
    left = num_chunks;
    while (left > 0) begin
      load_key(rand_key());
      for (int m = 0; m < 4 && left > 0; m++) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len && left > 0; i++) begin
          case ($urandom_range(0, 9))
            0:       cnt = 5'($urandom_range(17, 31));
            1:       cnt = 5'd0;
            2, 3:    cnt = 5'($urandom_range(1, 15));
            default: cnt = 5'd16;
          endcase
          send_chunk(rand64(), rand64(), cnt, i == 0);
          left--;
        end
      end
      drain();
    end
  endtask

  task automatic test_no_idle();
    quiet = 1;
    test_random_streams(100);
  endtask

  // Result receiver with random stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    keystream_out_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.payload.result_low !== exp_r.result_low) begin
          $error("result_low: expected %h, got %h", exp_r.result_low,
                 out_ch.payload.result_low);
          error_count++;
        end
        if (out_ch.payload.result_high !== exp_r.result_high) begin
          $error("result_high: expected %h, got %h", exp_r.result_high,
                 out_ch.payload.result_high);
          error_count++;
        end
        if (out_ch.payload.valid_bytes !== exp_r.valid_bytes) begin
          $error("valid_bytes: expected %0d, got %0d", exp_r.valid_bytes,
                 out_ch.payload.valid_bytes);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == 400000) begin
      $display("** aes256_ctr_le_counter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = RegKey0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    for (int i = 0; i < NumKeyRegs; i++) key_shadow[i] = '0;
    ctr_value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_streams(530);
    test_no_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("** aes256_ctr_le_counter_core: PASSED **");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d results never arrived", pending_results.size());
      $display("** aes256_ctr_le_counter_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ aes256_ctr_le_counter_core.f @@
src/actr_pkg.sv
src/actr_stream_if.sv
src/actr_keyexp.sv
src/actr_round.sv
src/aes256_ctr_le_counter_core.sv
tb/tb_top.sv
